// ===== design/rsrd_pkg.sv =====
// Shared types and constants for the range scan response decoder.
// No dependencies; imported by rsrd_frame_dec and range_scan_response_decoder.
package rsrd_pkg;

  localparam logic [7:0] CHAR_LF   = 8'd10;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // response_mode register codes
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_CONT   = 2'd1;
  localparam logic [1:0] MODE_PAIRS  = 2'd2;

  typedef enum logic [1:0] {
    KIND_STATUS    = 2'd0,
    KIND_TIMESTAMP = 2'd1,
    KIND_SAMPLE    = 2'd2,
    KIND_FRAME_END = 2'd3
  } rsrd_kind_t;

  typedef enum logic [1:0] {
    STAT_DATA  = 2'd0,
    STAT_ACK   = 2'd1,
    STAT_ERROR = 2'd2
  } rsrd_status_t;

  typedef struct packed {
    logic         valid;
    rsrd_kind_t   kind;
    rsrd_status_t code;
    logic [23:0]  stamp;
    logic [17:0]  distance;
    logic [17:0]  strength;
  } rsrd_result_t;

endpackage

// ===== design/rsrd_frame_dec.sv =====
// Line tracker and character decoder: turns one accepted response byte into
// at most one result request. Depends on rsrd_pkg.
module rsrd_frame_dec import rsrd_pkg::*; #(
  parameter int CHARS_PER_VALUE = 3,
  parameter int STAMP_CHARS     = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [1:0]   mode,
  input  logic         byte_valid,
  input  logic [7:0]   rx_byte,
  output rsrd_result_t res
);

  localparam int VAL_W = 6 * CHARS_PER_VALUE;
  localparam int ACC_W = 2 * VAL_W;
  localparam int CC_W  = $clog2(2 * CHARS_PER_VALUE + 1);
  localparam int SC_W  = $clog2(STAMP_CHARS + 1);

  localparam logic [CC_W-1:0] GROUP_ONE = CC_W'(CHARS_PER_VALUE);
  localparam logic [CC_W-1:0] GROUP_TWO = CC_W'(2 * CHARS_PER_VALUE);
  localparam logic [SC_W-1:0] STAMP_MAX = SC_W'(STAMP_CHARS);

  localparam logic [1:0] LINE_ECHO   = 2'd0;
  localparam logic [1:0] LINE_STATUS = 2'd1;
  localparam logic [1:0] LINE_STAMP  = 2'd2;
  localparam logic [1:0] LINE_DATA   = 2'd3;

  logic [1:0]       line_r,       line_nxt;
  logic             line_empty_r, line_empty_nxt;
  logic [7:0]       held_r,       held_nxt;
  logic             held_vld_r,   held_vld_nxt;
  logic [1:0]       stat_ok_r,    stat_ok_nxt;
  logic [1:0]       stat_cnt_r,   stat_cnt_nxt;
  logic             ignore_r,     ignore_nxt;
  logic [ACC_W-1:0] acc_r,        acc_nxt;
  logic [CC_W-1:0]  cnt_r,        cnt_nxt;
  logic [23:0]      stamp_r,      stamp_nxt;
  logic [SC_W-1:0]  stamp_cnt_r,  stamp_cnt_nxt;

  logic             is_lf;
  logic             pairs;
  logic [7:0]       held_off, byte_off;
  logic [ACC_W-1:0] acc_shift;
  logic [47:0]      acc_ext;
  logic [47:0]      acc_hi;
  logic [23:0]      acc_lo;
  logic [CC_W-1:0]  cnt_inc;
  logic [CC_W-1:0]  group;
  logic             is00, is99;
  rsrd_status_t     code;

  assign is_lf     = (rx_byte == CHAR_LF);
  assign pairs     = (mode == MODE_PAIRS);
  assign group     = pairs ? GROUP_TWO : GROUP_ONE;
  assign held_off  = held_r - CHAR_ZERO;
  assign byte_off  = rx_byte - CHAR_ZERO;
  assign acc_shift = {acc_r[ACC_W-7:0], held_off[5:0]};
  assign acc_ext   = 48'(acc_shift);
  assign acc_hi    = acc_ext >> VAL_W;
  assign acc_lo    = 24'(acc_shift[VAL_W-1:0]);
  assign cnt_inc   = cnt_r + 1'b1;

  assign is00 = (stat_cnt_r == 2'd2) && !stat_ok_r[0];
  assign is99 = (stat_cnt_r == 2'd2) && !stat_ok_r[1];

  always_comb begin
    if (mode == MODE_SINGLE) begin
      code = is00 ? STAT_DATA : STAT_ERROR;
    end else begin
      code = is00 ? STAT_ACK : (is99 ? STAT_DATA : STAT_ERROR);
    end
  end

  always_comb begin
    line_nxt       = line_r;
    line_empty_nxt = line_empty_r;
    held_nxt       = held_r;
    held_vld_nxt   = held_vld_r;
    stat_ok_nxt    = stat_ok_r;
    stat_cnt_nxt   = stat_cnt_r;
    ignore_nxt     = ignore_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    stamp_nxt      = stamp_r;
    stamp_cnt_nxt  = stamp_cnt_r;
    res            = '0;

    if (byte_valid) begin
      if (is_lf) begin
        if (line_empty_r) begin
          // empty line: close the frame and drop any partial group
          line_nxt       = LINE_ECHO;
          line_empty_nxt = 1'b1;
          held_nxt       = '0;
          held_vld_nxt   = 1'b0;
          stat_ok_nxt    = '0;
          stat_cnt_nxt   = '0;
          ignore_nxt     = 1'b0;
          acc_nxt        = '0;
          cnt_nxt        = '0;
          stamp_nxt      = '0;
          stamp_cnt_nxt  = '0;
          res.valid      = 1'b1;
          res.kind       = KIND_FRAME_END;
        end else begin
          if (line_r == LINE_STATUS) begin
            ignore_nxt = (code != STAT_DATA);
            res.valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.code   = code;
          end else if (line_r == LINE_STAMP && !ignore_r) begin
            res.valid = 1'b1;
            res.kind  = KIND_TIMESTAMP;
            res.stamp = stamp_r;
          end
          held_vld_nxt   = 1'b0;
          line_empty_nxt = 1'b1;
          if (line_r != LINE_DATA) begin
            line_nxt = line_r + 2'd1;
          end
        end
      end else begin
        line_empty_nxt = 1'b0;
        if (line_r == LINE_STATUS) begin
          if (stat_cnt_r != 2'd2) begin
            stat_ok_nxt[0] = stat_ok_r[0] | (rx_byte != CHAR_ZERO);
            stat_ok_nxt[1] = stat_ok_r[1] | (rx_byte != CHAR_NINE);
            stat_cnt_nxt   = stat_cnt_r + 2'd1;
          end
        end else if (line_r == LINE_STAMP) begin
          if (stamp_cnt_r < STAMP_MAX) begin
            stamp_nxt     = {stamp_r[17:0], byte_off[5:0]};
            stamp_cnt_nxt = stamp_cnt_r + 1'b1;
          end
        end else if (line_r == LINE_DATA && !ignore_r) begin
          // the last character of a line is its check character: hold one back
          if (held_vld_r) begin
            if (cnt_inc >= group) begin
              acc_nxt    = '0;
              cnt_nxt    = '0;
              res.valid  = 1'b1;
              res.kind   = KIND_SAMPLE;
              if (pairs) begin
                res.distance = acc_hi[17:0];
                res.strength = acc_lo[17:0];
              end else begin
                res.distance = acc_ext[17:0];
              end
            end else begin
              acc_nxt = acc_shift;
              cnt_nxt = cnt_inc;
            end
          end
          held_nxt     = rx_byte;
          held_vld_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r       <= LINE_ECHO;
      line_empty_r <= 1'b1;
      held_r       <= '0;
      held_vld_r   <= 1'b0;
      stat_ok_r    <= '0;
      stat_cnt_r   <= '0;
      ignore_r     <= 1'b0;
      acc_r        <= '0;
      cnt_r        <= '0;
      stamp_r      <= '0;
      stamp_cnt_r  <= '0;
    end else begin
      line_r       <= line_nxt;
      line_empty_r <= line_empty_nxt;
      held_r       <= held_nxt;
      held_vld_r   <= held_vld_nxt;
      stat_ok_r    <= stat_ok_nxt;
      stat_cnt_r   <= stat_cnt_nxt;
      ignore_r     <= ignore_nxt;
      acc_r        <= acc_nxt;
      cnt_r        <= cnt_nxt;
      stamp_r      <= stamp_nxt;
      stamp_cnt_r  <= stamp_cnt_nxt;
    end
  end

  a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < GROUP_TWO)
    else $error("value group count overran the pair size");

  a_status_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    stat_cnt_r != 2'd3)
    else $error("status character count passed two");

  a_sample_line: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.kind == KIND_SAMPLE) |-> (line_r == LINE_DATA && !ignore_r))
    else $error("sample request outside the data lines");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_valid && is_lf && line_empty_r) |=>
      (line_r == LINE_ECHO && line_empty_r && cnt_r == '0 && !held_vld_r))
    else $error("frame state not cleared after empty line");

endmodule

// ===== design/range_scan_response_decoder.sv =====
// Top level of the range scan response decoder: mode register, frame decoder
// and output register. Depends on rsrd_pkg and rsrd_frame_dec.
//
//  channel  direction  tdata / data                          tuser
//  in_      slave      [7:0] rx_byte                         -
//  out_     master     status_code, timestamp, distance,     [1:0] result_kind
//                      strength (see port comments)
//  cfg_     write      [1:0] response_mode                   -
//
// One byte is taken per cycle while the output register is not stalled; its result
// appears in the output register the next cycle.
// in_tready stays high while the output register is empty or being drained;
// only a stalled, full output register holds off the input.
// Reset (rst_n low, synchronous) sets response_mode to continuous distance and
// starts a new frame.
module range_scan_response_decoder import rsrd_pkg::*; #(
  parameter int CHARS_PER_VALUE = 3,
  parameter int STAMP_CHARS     = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [1:0] status_code, [25:2] timestamp,
                                   // [43:26] distance, [61:44] strength, [63:62] zero
  output logic [1:0]  out_tuser,   // [1:0] result_kind
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data  // [1:0] response_mode
);

  logic         mode_r;
  logic [1:0]   mode_val_r;
  logic         accept;
  rsrd_result_t res;
  logic         out_vld_r, out_vld_nxt;
  rsrd_result_t out_res_r;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_val_r <= MODE_CONT;
      mode_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_val_r <= cfg_wr_data;
      mode_r     <= 1'b1;
    end
  end

  rsrd_frame_dec #(
    .CHARS_PER_VALUE (CHARS_PER_VALUE),
    .STAMP_CHARS     (STAMP_CHARS)
  ) u_frame_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_val_r),
    .byte_valid (accept),
    .rx_byte    (in_tdata),
    .res        (res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (accept) begin
      out_vld_nxt = res.valid;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // load a new request only when a taken byte yields one; hold otherwise
  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {2'b00, out_res_r.strength, out_res_r.distance,
                       out_res_r.stamp, out_res_r.code};

  a_mode_legal_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !mode_r |-> (mode_val_r == MODE_CONT))
    else $error("mode changed without a configuration write");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !accept)
    else $error("byte taken while a stalled result is pending");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.valid) |=> (out_vld_r && out_tuser == $past(res.kind)))
    else $error("result request not presented on the output");

endmodule

// ===== test/range_scan_response_decoder_tb.sv =====
`timescale 1ns / 100ps
// Testbench for range_scan_response_decoder: drives response bytes and mode writes,
// predicts status, timestamp, sample and frame end records. Depends on rsrd_pkg.
module range_scan_response_decoder_tb;
  import rsrd_pkg::*;

  localparam int VALUE_CHARS = 3;
  localparam int STAMP_LEN   = 4;
  localparam int BYTE_TARGET = 1050;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    rsrd_kind_t   kind;
    rsrd_status_t code;
    logic [23:0]  stamp;
    logic [17:0]  distance;
    logic [17:0]  strength;
  } scan_record_t;

  class scan_decode_scoreboard;
    logic [1:0]   mode;
    logic [1:0]   line_idx;
    bit           line_blank;
    logic [7:0]   held_byte;
    bit           held_ok;
    logic [1:0]   status_miss;  // bit0: left "00", bit1: left "99"
    logic [1:0]   status_seen;
    bit           skip_frame;
    logic [35:0]  value_acc;
    logic [2:0]   value_chars;
    logic [23:0]  stamp_acc;
    logic [2:0]   stamp_chars;
    scan_record_t decoded_q[$];
    int           errors;

    function new();
      mode = MODE_CONT;
      errors = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      line_idx = 0;
      line_blank = 1;
      held_byte = 0;
      held_ok = 0;
      status_miss = 0;
      status_seen = 0;
      skip_frame = 0;
      value_acc = 0;
      value_chars = 0;
      stamp_acc = 0;
      stamp_chars = 0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function logic [5:0] six_bits(input logic [7:0] c);
      logic [7:0] t;
      t = c - CHAR_ZERO;
      return t[5:0];
    endfunction

    function void add_data_char(input logic [7:0] c);
      scan_record_t r;
      int group;
      r = '0;
      group = (mode == MODE_PAIRS) ? 2 * VALUE_CHARS : VALUE_CHARS;
      value_acc = {value_acc[29:0], six_bits(c)};
      value_chars++;
      if (value_chars >= group) begin
        r.kind = KIND_SAMPLE;
        if (mode == MODE_PAIRS) begin
          r.distance = value_acc[35:18];
          r.strength = value_acc[17:0];
        end else begin
          r.distance = value_acc[17:0];
        end
        value_acc = 0;
        value_chars = 0;
        decoded_q.push_back(r);
      end
    endfunction

    // Advance the predicted decoder by one accepted byte.
    function void note_request(input logic [7:0] c);
      scan_record_t r;
      bit is00;
      bit is99;
      r = '0;
      if (c == CHAR_LF) begin
        if (line_blank) begin
          restart_frame();
          r.kind = KIND_FRAME_END;
          decoded_q.push_back(r);
          return;
        end
        if (line_idx == 1) begin
          is00 = (status_seen >= 2) && !status_miss[0];
          is99 = (status_seen >= 2) && !status_miss[1];
          r.kind = KIND_STATUS;
          if (mode == MODE_SINGLE) r.code = is00 ? STAT_DATA : STAT_ERROR;
          else if (is00) r.code = STAT_ACK;
          else if (is99) r.code = STAT_DATA;
          else r.code = STAT_ERROR;
          skip_frame = (r.code != STAT_DATA);
          decoded_q.push_back(r);
        end else if (line_idx == 2 && !skip_frame) begin
          r.kind = KIND_TIMESTAMP;
          r.stamp = stamp_acc;
          decoded_q.push_back(r);
        end
        // drop the check character held from this line
        held_ok = 0;
        line_blank = 1;
        if (line_idx < 3) line_idx++;
        return;
      end
      line_blank = 0;
      if (line_idx == 1) begin
        if (status_seen < 2) begin
          if (c != CHAR_ZERO) status_miss[0] = 1;
          if (c != CHAR_NINE) status_miss[1] = 1;
          status_seen++;
        end
      end else if (line_idx == 2) begin
        if (stamp_chars < STAMP_LEN) begin
          stamp_acc = {stamp_acc[17:0], six_bits(c)};
          stamp_chars++;
        end
      end else if (line_idx == 3 && !skip_frame) begin
        if (held_ok) add_data_char(held_byte);
        held_byte = c;
        held_ok = 1;
      end
    endfunction

    function void compare_field(input string name, input logic [23:0] want,
                                input logic [23:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input logic [1:0] kind, input logic [63:0] data);
      scan_record_t e;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected record, expected none, actual kind %0d data %h",
                 $time, kind, data);
        errors++;
        return;
      end
      e = decoded_q.pop_front();
      compare_field("kind", 24'(e.kind), 24'(kind));
      compare_field("status_code", 24'(e.code), 24'(data[1:0]));
      compare_field("timestamp", e.stamp, data[25:2]);
      compare_field("distance", 24'(e.distance), 24'(data[43:26]));
      compare_field("strength", 24'(e.strength), 24'(data[61:44]));
      compare_field("pad", 24'd0, 24'(data[63:62]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;

  scan_decode_scoreboard sb;
  int bytes_sent;
  int cycle_count = 0;
  bit idle_in;
  bit idle_out;

  range_scan_response_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_in ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    do @(posedge clk); while (!in_tready);
    sb.note_request(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Write the mode only once the decoder has drained.
  task automatic write_mode(input logic [1:0] m);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.mode = m;
  endtask

  function automatic logic [7:0] any_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
    return b;
  endfunction

  function automatic logic [7:0] data_char();
    if ($urandom_range(0, 7) == 0) return any_char();
    return 8'($urandom_range(8'h30, 8'h6F));
  endfunction

  function automatic logic [7:0] status_char();
    case ($urandom_range(0, 2))
      0: return CHAR_ZERO;
      1: return CHAR_NINE;
      default: return any_char();
    endcase
  endfunction

  task automatic run_frame();
    logic [7:0] q[$];
    int n;
    int pick;
    if ($urandom_range(0, 6) == 0) begin
      // noise: random bytes with line feeds sprinkled in, then flush the frame
      n = $urandom_range(5, 40);
      repeat (n) q.push_back(($urandom_range(0, 7) == 0) ? CHAR_LF : any_char());
      q.push_back(CHAR_LF);
      q.push_back(CHAR_LF);
    end else begin
      n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
      repeat (n) q.push_back(any_char());
      q.push_back(CHAR_LF);
      pick = $urandom_range(0, 11);
      if (pick < 7) begin
        q.push_back(sb.mode == MODE_SINGLE ? CHAR_ZERO : CHAR_NINE);
        q.push_back(sb.mode == MODE_SINGLE ? CHAR_ZERO : CHAR_NINE);
      end else if (pick < 9) begin
        q.push_back(pick == 7 ? CHAR_ZERO : CHAR_NINE);
        q.push_back(pick == 7 ? CHAR_ZERO : CHAR_NINE);
      end else if (pick == 9) begin
        q.push_back(status_char());
      end else begin
        repeat ($urandom_range(2, 4)) q.push_back(status_char());
      end
      q.push_back(CHAR_LF);
      repeat ($urandom_range(1, 6)) q.push_back(data_char());
      q.push_back(CHAR_LF);
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(1, 16)) q.push_back(data_char());
        q.push_back(CHAR_LF);
      end
      q.push_back(CHAR_LF);
    end
    foreach (q[i]) send_byte(q[i]);
  endtask

  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (idle_out && $urandom_range(0, 1) == 1) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tuser, out_tdata);
      @(negedge clk);
    end
  end

  initial begin
    int frame_no;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 2'd0;
    bytes_sent = 0;
    idle_in = 1'b0;
    idle_out = 1'b0;
    frame_no = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset mode: blank start, echo with extreme bytes, short stamp, one sample
    send_byte(CHAR_LF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_LF);
    send_text("99\n0oo\nooo0?\n\n");
    // one-character status is an error
    send_text("x\n9\n\n");

    while (bytes_sent < BYTE_TARGET) begin
      if (frame_no % 5 == 0) write_mode(2'(frame_no / 5));
      else if ($urandom_range(0, 9) == 0) write_mode(2'($urandom_range(0, 3)));
      idle_in = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      run_frame();
      frame_no++;
    end

    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
